// File: rtl/bba_pkg.sv
// bba_pkg: shared types and constants of the buddy bitmap allocator
// used by bba_ctrl, bba_datapath and buddy_bitmap_allocator; no dependencies
package bba_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_SIZE  = 2'd1,
      ST_TOO_LARGE  = 2'd2,
      ST_NO_FREE    = 2'd3
   } status_type;

   // request kinds
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // configuration register indexes
   localparam logic [1:0] CSR_LEVELS_IN_USE   = 2'd0;
   localparam logic [1:0] CSR_MIN_BLOCK_BYTES = 2'd1;
   localparam logic [1:0] CSR_MEMORY_BYTES    = 2'd2;

   localparam logic [3:0]  RST_LEVELS_IN_USE   = 4'd8;
   localparam logic [16:0] RST_MIN_BLOCK_BYTES = 17'd16;
   localparam logic [24:0] RST_MEMORY_BYTES    = 25'd2048;

   typedef struct packed {
      logic [3:0]  levels_in_use;
      logic [16:0] min_block_bytes;
      logic [24:0] memory_bytes;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       clear_step;
      logic       load_req;
      logic       size_init;
      logic       size_step;
      logic       scan_init;
      logic       scan_step;
      logic       sub_init_alloc;
      logic       sub_init_free;
      logic       sub_step;
      logic       anc_step;
      logic       buddy_read;
      logic       free_climb;
      logic       mul_step;
      logic       rsp_fire;
      status_type rsp_code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic op_free;
      logic free_oob;
      logic size_zero;
      logic size_stop;
      logic size_too_large;
      logic scan_hit;
      logic scan_miss;
      logic sub_done;
      logic node_root;
      logic buddy_busy;
   } dp_status_type;

endpackage

// File: rtl/bba_ctrl.sv
// bba_ctrl: sequencing state machine of the buddy bitmap allocator
// depends on bba_pkg; drives bba_datapath through cmd_type, reads dp_status_type
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bba_pkg::dp_status_type dp_status,
   output bba_pkg::cmd_type       cmd
);

   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_DECODE   = 11'b000_0000_0100,
      S_SIZE     = 11'b000_0000_1000,
      S_SCAN     = 11'b000_0001_0000,
      S_SUB      = 11'b000_0010_0000,
      S_ANC      = 11'b000_0100_0000,
      S_FREE_UP  = 11'b000_1000_0000,
      S_FREE_CHK = 11'b001_0000_0000,
      S_MUL      = 11'b010_0000_0000,
      S_RESP     = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_code = bba_pkg::ST_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (dp_status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (dp_status.op_free) begin
               if (dp_status.free_oob) begin
                  cmd.rsp_fire = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  cmd.sub_init_free = 1'b1;
                  state_in          = S_SUB;
               end
            end else if (dp_status.size_zero) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_code = bba_pkg::ST_ZERO_SIZE;
               state_in     = S_IDLE;
            end else begin
               cmd.size_init = 1'b1;
               state_in      = S_SIZE;
            end
         end
         S_SIZE: begin
            if (dp_status.size_stop) begin
               if (dp_status.size_too_large) begin
                  cmd.rsp_fire = 1'b1;
                  cmd.rsp_code = bba_pkg::ST_TOO_LARGE;
                  state_in     = S_IDLE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            end else begin
               cmd.size_step = 1'b1;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_hit) begin
               cmd.sub_init_alloc = 1'b1;
               state_in           = S_SUB;
            end else if (dp_status.scan_miss) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_code = bba_pkg::ST_NO_FREE;
               state_in     = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SUB: begin
            cmd.sub_step = 1'b1;
            if (dp_status.sub_done) begin
               state_in = dp_status.op_free ? S_FREE_UP : S_ANC;
            end
         end
         S_ANC: begin
            if (dp_status.node_root) begin
               state_in = S_MUL;
            end else begin
               cmd.anc_step = 1'b1;
            end
         end
         S_FREE_UP: begin
            if (dp_status.node_root) begin
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.buddy_read = 1'b1;
               state_in       = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            if (dp_status.buddy_busy) begin
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.free_climb = 1'b1;
               state_in       = S_FREE_UP;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            cmd.rsp_fire = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/bba_datapath.sv
// bba_datapath: busy-bit memory, size search, level scan, tree walks and offset math
// depends on bba_pkg; commanded by bba_ctrl
module bba_datapath #(
   parameter int LEVELS       = 8,
   parameter int HEADER_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bba_pkg::cmd_type       cmd,
   input  bba_pkg::cfg_type       cfg,
   input  logic                   req_op,
   input  logic [23:0]            req_request_size,
   input  logic [7:0]             req_free_index,
   output bba_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_block_index,
   output logic [2:0]             rsp_block_level,
   output logic [23:0]            rsp_byte_offset
);

   localparam int NODE_W     = LEVELS;
   localparam int PTR_W      = LEVELS + 1;
   localparam int NODE_COUNT = (1 << LEVELS) - 1;
   localparam int LV_W       = $clog2(LEVELS + 1);
   localparam int PROD_W     = NODE_W + 24;

   // busy-bit memory
   logic busy_bits_ff [NODE_COUNT];
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic              wr_data;
   logic              rd_en;
   logic [NODE_W-1:0] rd_addr;
   logic              rd_data_ff;

   // request
   logic        op_ff, op_in;
   logic [23:0] size_ff, size_in;
   logic [7:0]  fidx_ff, fidx_in;

   // size search
   logic [25:0]     bucket_ff, bucket_in;
   logic [LV_W-1:0] steps_ff, steps_in;
   logic [LV_W-1:0] lv_ff, lv_in;
   logic [24:0]     need_bytes;

   // level scan
   logic [LV_W-1:0]  level_ff, level_in;
   logic [LV_W-1:0]  level_calc;
   logic [PTR_W-1:0] first_ff, first_in;
   logic [PTR_W-1:0] last_ff, last_in;
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [PTR_W-1:0] rd_node_ff, rd_node_in;
   logic             rd_valid_ff, rd_valid_in;

   // tree walks
   logic [NODE_W-1:0] found_ff, found_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W-1:0] parent;
   logic [NODE_W-1:0] buddy;
   logic [NODE_W-1:0] sub_base;
   logic [PTR_W-1:0]  row_first_ff, row_first_in;
   logic [PTR_W-1:0]  row_last_ff, row_last_in;
   logic [PTR_W-1:0]  sub_ptr_ff, sub_ptr_in;
   logic [PTR_W-1:0]  next_first;
   logic              sub_val_ff, sub_val_in;
   logic [NODE_W-1:0] clr_ptr_ff, clr_ptr_in;

   // offset
   logic [23:0]       prod_ff, prod_in;
   logic [PROD_W-1:0] prod_full;
   logic [NODE_W-1:0] pos;
   logic [24:0]       mem_shift;

   // response
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_index_ff, rsp_index_in;
   logic [2:0]  rsp_level_ff, rsp_level_in;
   logic [23:0] rsp_offset_ff, rsp_offset_in;

   assign need_bytes = {1'b0, size_ff} + 25'(HEADER_BYTES);
   assign level_calc = lv_ff - steps_ff - LV_W'(1);
   assign parent     = (node_ff - NODE_W'(1)) >> 1;
   assign buddy      = node_ff[0] ? (node_ff + NODE_W'(1)) : (node_ff - NODE_W'(1));
   assign next_first = (row_first_ff << 1) + PTR_W'(1);
   assign sub_base   = cmd.sub_init_alloc ? rd_node_ff[NODE_W-1:0] : NODE_W'(fidx_ff);
   assign pos        = found_ff - first_ff[NODE_W-1:0];
   assign mem_shift  = cfg.memory_bytes >> level_ff;
   assign prod_full  = PROD_W'(pos) * PROD_W'(mem_shift[23:0]);

   // status toward the controller
   always_comb begin
      dp_status                = '0;
      dp_status.clear_last     = (clr_ptr_ff == NODE_W'(NODE_COUNT - 1));
      dp_status.op_free        = (op_ff == bba_pkg::OP_FREE);
      dp_status.free_oob       = (17'(fidx_ff) >= 17'(NODE_COUNT));
      dp_status.size_zero      = (size_ff == 24'd0);
      dp_status.size_stop      = (bucket_ff >= {1'b0, need_bytes}) || (steps_ff >= lv_ff);
      dp_status.size_too_large = (bucket_ff < {1'b0, need_bytes}) || (steps_ff >= lv_ff);
      dp_status.scan_hit       = rd_valid_ff && !rd_data_ff;
      dp_status.scan_miss      = rd_valid_ff && rd_data_ff && (rd_node_ff == last_ff);
      dp_status.sub_done       = (sub_ptr_ff == row_last_ff) &&
                                 (next_first >= PTR_W'(NODE_COUNT));
      dp_status.node_root      = (node_ff == '0);
      dp_status.buddy_busy     = rd_data_ff;
   end

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ptr_ff;
      wr_data = 1'b0;
      rd_en   = 1'b0;
      rd_addr = scan_ptr_ff[NODE_W-1:0];
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.sub_step) begin
         wr_en   = 1'b1;
         wr_addr = sub_ptr_ff[NODE_W-1:0];
         wr_data = sub_val_ff;
      end else if (cmd.anc_step) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = 1'b1;
      end else if (cmd.free_climb) begin
         wr_en   = 1'b1;
         wr_addr = parent;
      end
      if (cmd.scan_step && (scan_ptr_ff <= last_ff)) begin
         rd_en = 1'b1;
      end else if (cmd.buddy_read) begin
         rd_en   = 1'b1;
         rd_addr = buddy;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         busy_bits_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= busy_bits_ff[rd_addr];
      end
   end

   // next values
   always_comb begin
      op_in         = op_ff;
      size_in       = size_ff;
      fidx_in       = fidx_ff;
      bucket_in     = bucket_ff;
      steps_in      = steps_ff;
      lv_in         = lv_ff;
      level_in      = level_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_node_in    = rd_node_ff;
      rd_valid_in   = 1'b0;
      found_in      = found_ff;
      node_in       = node_ff;
      row_first_in  = row_first_ff;
      row_last_in   = row_last_ff;
      sub_ptr_in    = sub_ptr_ff;
      sub_val_in    = sub_val_ff;
      clr_ptr_in    = clr_ptr_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_offset_in = rsp_offset_ff;

      if (cmd.clear_step) begin
         clr_ptr_in = clr_ptr_ff + NODE_W'(1);
      end
      if (cmd.load_req) begin
         op_in   = req_op;
         size_in = req_request_size;
         fidx_in = req_free_index;
      end
      if (cmd.size_init) begin
         bucket_in = 26'(cfg.min_block_bytes);
         steps_in  = '0;
         if ({1'b0, cfg.levels_in_use} > 5'(LEVELS)) begin
            lv_in = LV_W'(LEVELS);
         end else begin
            lv_in = LV_W'(cfg.levels_in_use);
         end
      end
      if (cmd.size_step) begin
         bucket_in = bucket_ff << 1;
         steps_in  = steps_ff + LV_W'(1);
      end
      if (cmd.scan_init) begin
         level_in    = level_calc;
         first_in    = (PTR_W'(1) << level_calc) - PTR_W'(1);
         last_in     = (PTR_W'(1) << (level_calc + LV_W'(1))) - PTR_W'(2);
         scan_ptr_in = (PTR_W'(1) << level_calc) - PTR_W'(1);
      end
      if (cmd.scan_step && (scan_ptr_ff <= last_ff)) begin
         scan_ptr_in = scan_ptr_ff + PTR_W'(1);
         rd_node_in  = scan_ptr_ff;
         rd_valid_in = 1'b1;
      end
      if (cmd.sub_init_alloc || cmd.sub_init_free) begin
         found_in     = sub_base;
         node_in      = sub_base;
         row_first_in = {1'b0, sub_base};
         row_last_in  = {1'b0, sub_base};
         sub_ptr_in   = {1'b0, sub_base};
         sub_val_in   = cmd.sub_init_alloc;
      end
      if (cmd.sub_step) begin
         if (sub_ptr_ff == row_last_ff) begin
            row_first_in = next_first;
            row_last_in  = (row_last_ff << 1) + PTR_W'(2);
            sub_ptr_in   = next_first;
         end else begin
            sub_ptr_in = sub_ptr_ff + PTR_W'(1);
         end
      end
      if (cmd.anc_step || cmd.free_climb) begin
         node_in = parent;
      end
      if (cmd.mul_step) begin
         prod_in = prod_full[23:0];
      end
      if (cmd.rsp_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_code;
         if ((cmd.rsp_code == bba_pkg::ST_OK) && (op_ff == bba_pkg::OP_ALLOC)) begin
            rsp_index_in  = 8'(found_ff);
            rsp_level_in  = 3'(level_ff);
            rsp_offset_in = prod_ff + 24'(HEADER_BYTES);
         end else begin
            rsp_index_in  = '0;
            rsp_level_in  = '0;
            rsp_offset_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ptr_ff   <= clr_ptr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      fidx_ff       <= fidx_in;
      bucket_ff     <= bucket_in;
      steps_ff      <= steps_in;
      lv_ff         <= lv_in;
      level_ff      <= level_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      scan_ptr_ff   <= scan_ptr_in;
      rd_node_ff    <= rd_node_in;
      found_ff      <= found_in;
      node_ff       <= node_in;
      row_first_ff  <= row_first_in;
      row_last_ff   <= row_last_in;
      sub_ptr_ff    <= sub_ptr_in;
      sub_val_ff    <= sub_val_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_block_level = rsp_level_ff;
   assign rsp_byte_offset = rsp_offset_ff;

endmodule

// File: rtl/buddy_bitmap_allocator.sv
// buddy_bitmap_allocator: top level, configuration registers and assertions
// depends on bba_pkg, bba_ctrl and bba_datapath
//
// binary buddy allocator over a heap-ordered tree of busy bits, one bit per node
// (2^LEVELS-1 nodes, node 0 is the whole region, children of i are 2i+1 and 2i+2).
// a transaction is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid high in the cycle that busy drops,
// and the receiver cannot stall it. after reset the busy-bit memory is cleared
// one entry per cycle, and busy stays high until all of it is cleared. an allocate
// doubles the size bucket until request plus header fit, scans the target level
// for a free node, marks its subtree and then its ancestors busy and computes the
// offset; a free clears the subtree, then each parent while the buddy is free, up
// to a busy buddy or the root; a zero size or out of range free is answered from
// decode. all of it is bound by the single write port and single registered read
// port of the busy-bit memory. configuration writes are always taken
// (csr_ready is tied high) and must only happen while no transaction is in flight.
module buddy_bitmap_allocator #(
   parameter int LEVELS       = 8,
   parameter int HEADER_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,

   // request transaction
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [23:0] req_request_size,
   input  logic [7:0]  req_free_index,

   // result transaction
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_block_index,
   output logic [2:0]  rsp_block_level,
   output logic [23:0] rsp_byte_offset,

   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_wdata
);

   bba_pkg::cfg_type       cfg_ff;
   bba_pkg::cfg_type       cfg_in;
   bba_pkg::cmd_type       cmd;
   bba_pkg::dp_status_type dp_status;

   // register writes take effect in the next cycle, nothing to hold off
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bba_pkg::CSR_LEVELS_IN_USE:   cfg_in.levels_in_use   = csr_wdata[3:0];
            bba_pkg::CSR_MIN_BLOCK_BYTES: cfg_in.min_block_bytes = csr_wdata[16:0];
            bba_pkg::CSR_MEMORY_BYTES:    cfg_in.memory_bytes    = csr_wdata;
            default: begin
               // writes past the register list are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.levels_in_use   <= bba_pkg::RST_LEVELS_IN_USE;
         cfg_ff.min_block_bytes <= bba_pkg::RST_MIN_BLOCK_BYTES;
         cfg_ff.memory_bytes    <= bba_pkg::RST_MEMORY_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // memory, counters and arithmetic
   bba_datapath #(
      .LEVELS       (LEVELS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .req_op           (req_op),
      .req_request_size (req_request_size),
      .req_free_index   (req_free_index),
      .dp_status        (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_block_index  (rsp_block_index),
      .rsp_block_level  (rsp_block_level),
      .rsp_byte_offset  (rsp_byte_offset)
   );

`ifndef NO_ASSERTIONS
   // an accepted transaction always keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // a result is a single-cycle strobe, never two in a row
   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // error results carry no block
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != bba_pkg::ST_OK)) |->
      ((rsp_block_index == 8'd0) && (rsp_block_level == 3'd0) &&
       (rsp_byte_offset == 24'd0)))
      else $error("error result with nonzero block fields");

   // only one command to the memory write port at a time
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.sub_step, cmd.anc_step, cmd.free_climb}))
      else $error("conflicting memory write commands");
`endif

endmodule
